>>> sv/rss_pkg.sv
// Shared types and constants for the rolling-sum substring search.
package rss_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_POS_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_FOUND     = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic clear;
    logic append;
  } pat_cmd_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } win_cmd_t;

endpackage

>>> sv/rss_pattern.sv
// Pattern store: shift-in byte register, length, thermometer mask, byte sum, overflow flag.
module rss_pattern #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rss_pkg::pat_cmd_t                            cmd_i,
  input  logic [rss_pkg::BYTE_W-1:0]                   byte_i,
  output logic [LEN_W-1:0]                             len_o,
  output logic [MAX_PATTERN-1:0]                       mask_o,
  output logic [MAX_PATTERN-1:0][rss_pkg::BYTE_W-1:0]  bytes_o,
  output logic [rss_pkg::SUM_W-1:0]                    sum_o,
  output logic                                         ovf_o
);

  // Newest pattern byte sits at index 0, so pattern byte i is bytes_q[len-1-i].
  logic [MAX_PATTERN-1:0][rss_pkg::BYTE_W-1:0] bytes_q, bytes_d;
  logic [LEN_W-1:0]                            len_q, len_d;
  logic [MAX_PATTERN-1:0]                      mask_q, mask_d;
  logic [rss_pkg::SUM_W-1:0]                   sum_q, sum_d;
  logic                                        ovf_q, ovf_d;
  logic                                        room;

  assign room = (len_q < LEN_W'(MAX_PATTERN));

  always_comb begin
    bytes_d = bytes_q;
    len_d   = len_q;
    mask_d  = mask_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear) begin
      len_d  = '0;
      mask_d = '0;
      sum_d  = '0;
      ovf_d  = 1'b0;
    end else if (cmd_i.append) begin
      if (room) begin
        bytes_d[0] = byte_i;
        for (int k = 1; k < MAX_PATTERN; k++) begin
          bytes_d[k] = bytes_q[k-1];
        end
        len_d  = len_q + LEN_W'(1);
        mask_d = (mask_q << 1) | MAX_PATTERN'(1);
        sum_d  = sum_q + rss_pkg::SUM_W'(byte_i);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      mask_q <= '0;
      sum_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      mask_q <= mask_d;
      sum_q  <= sum_d;
      ovf_q  <= ovf_d;
    end
  end

  assign len_o   = len_q;
  assign mask_o  = mask_q;
  assign bytes_o = bytes_q;
  assign sum_o   = sum_q;
  assign ovf_o   = ovf_q;

endmodule

>>> sv/rss_window.sv
// Text window: byte shift line, rolling sum, saturating count and parallel pattern compare.
module rss_window #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned LEN_W         = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rss_pkg::win_cmd_t                            cmd_i,
  input  logic [rss_pkg::BYTE_W-1:0]                   byte_i,
  input  logic [LEN_W-1:0]                             pat_len_i,
  input  logic [MAX_PATTERN-1:0]                       pat_mask_i,
  input  logic [MAX_PATTERN-1:0][rss_pkg::BYTE_W-1:0]  pat_bytes_i,
  input  logic [rss_pkg::SUM_W-1:0]                    pat_sum_i,
  output logic                                         hit_o,
  output logic [POSITION_BITS-1:0]                     pos_o
);

  localparam logic [POSITION_BITS-1:0] CountMax = '1;

  logic [MAX_PATTERN-1:0][rss_pkg::BYTE_W-1:0] win_q, win_d, win_next;
  logic [rss_pkg::SUM_W-1:0]                   sum_q, sum_d, sum_next;
  logic [POSITION_BITS-1:0]                    count_q, count_d, count_next;
  logic [rss_pkg::BYTE_W-1:0]                  leaving;
  logic [MAX_PATTERN-1:0]                      byte_ok;
  logic [POSITION_BITS-1:0]                    len_wide;

  assign len_wide = POSITION_BITS'(pat_len_i);

  // Window as it stands after the incoming text byte.
  always_comb begin
    leaving = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (pat_len_i == LEN_W'(k + 1)) leaving = win_q[k];
    end
    win_next[0] = byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = win_q[k-1];
    end
    if (pat_len_i != '0) begin
      sum_next = sum_q + rss_pkg::SUM_W'(byte_i) - rss_pkg::SUM_W'(leaving);
    end else begin
      sum_next = sum_q;
    end
    count_next = (count_q == CountMax) ? count_q : count_q + POSITION_BITS'(1);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      byte_ok[k] = !pat_mask_i[k] || (win_next[k] == pat_bytes_i[k]);
    end
  end

  assign hit_o = (pat_len_i != '0) && (count_next >= len_wide) &&
                 (sum_next == pat_sum_i) && (&byte_ok);
  assign pos_o = (count_next == CountMax) ? CountMax : count_next - len_wide;

  always_comb begin
    win_d   = win_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (cmd_i.restart) begin
      win_d   = '0;
      sum_d   = '0;
      count_d = '0;
    end else if (cmd_i.shift) begin
      win_d   = win_next;
      sum_d   = sum_next;
      count_d = count_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      win_q   <= win_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

>>> sv/rolling_sum_substring_search.sv
// Rolling-sum substring search: input register, match decision and result register.
//
// Channels: the input channel carries kind_i (clear, append pattern byte, text byte,
// end of text) and byte_value_i; the output channel carries status_o and
// match_position_o. Both use valid/ready; a beat moves when valid and ready are high.
// A beat is held in an input register, where the pattern and window update, the
// rolling sum is checked and the window is compared with the pattern in parallel;
// a result then lands in the output register. One beat per cycle is accepted while
// the input register does not stall.
// A text byte yields a result only for the first match; end of text yields one unless
// a match was already reported. Clear and append beats give no result.
// While a result waits in the output register, items that produce no result keep
// flowing; the input register stalls only when it holds a result-producing item and
// the output register is full and not taken, which then drops in_ready_o.
// Reset empties the pattern, zeros the window, sum and position count, and leaves
// both registers empty; the block accepts beats as soon as reset is released.
module rolling_sum_substring_search #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rss_pkg::KIND_W-1:0]    kind_i,
  input  logic [rss_pkg::BYTE_W-1:0]    byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rss_pkg::STATUS_W-1:0]  status_o,
  output logic [rss_pkg::OUT_POS_W-1:0] match_position_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic                                        s1_valid_q, s1_valid_d;
  rss_pkg::kind_e                              kind_q;
  logic [rss_pkg::BYTE_W-1:0]                  byte_q;
  logic                                        done_q, done_d;
  logic                                        out_valid_q, out_valid_d;
  rss_pkg::status_e                            status_q, status_d;
  logic [rss_pkg::OUT_POS_W-1:0]               pos_q, pos_d;

  logic                                        s1_fire;
  logic                                        has_res;
  rss_pkg::pat_cmd_t                           pat_cmd;
  rss_pkg::win_cmd_t                           win_cmd;
  logic [LenW-1:0]                             pat_len;
  logic [MAX_PATTERN-1:0]                      pat_mask;
  logic [MAX_PATTERN-1:0][rss_pkg::BYTE_W-1:0] pat_bytes;
  logic [rss_pkg::SUM_W-1:0]                   pat_sum;
  logic                                        pat_ovf;
  logic                                        hit;
  logic [POSITION_BITS-1:0]                    hit_pos;
  logic [31:0]                                 hit_pos_wide;
  rss_pkg::status_e                            res_status;
  logic [rss_pkg::OUT_POS_W-1:0]               res_pos;

  rss_pattern #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LenW)
  ) u_pattern (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pat_cmd),
    .byte_i  (byte_q),
    .len_o   (pat_len),
    .mask_o  (pat_mask),
    .bytes_o (pat_bytes),
    .sum_o   (pat_sum),
    .ovf_o   (pat_ovf)
  );

  rss_window #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS),
    .LEN_W         (LenW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (win_cmd),
    .byte_i      (byte_q),
    .pat_len_i   (pat_len),
    .pat_mask_i  (pat_mask),
    .pat_bytes_i (pat_bytes),
    .pat_sum_i   (pat_sum),
    .hit_o       (hit),
    .pos_o       (hit_pos)
  );

  assign hit_pos_wide = 32'(hit_pos);

  // Decide whether the held item yields a result, and which.
  always_comb begin
    has_res    = 1'b0;
    res_status = rss_pkg::ST_NOT_FOUND;
    res_pos    = '0;
    case (kind_q)
      rss_pkg::KIND_TEXT: begin
        if (!done_q && !pat_ovf) begin
          if (pat_len == '0) begin
            has_res    = 1'b1;
            res_status = rss_pkg::ST_FOUND;
          end else if (hit) begin
            has_res    = 1'b1;
            res_status = rss_pkg::ST_FOUND;
            res_pos    = hit_pos_wide[rss_pkg::OUT_POS_W-1:0];
          end
        end
      end
      rss_pkg::KIND_END: begin
        if (!done_q) begin
          has_res = 1'b1;
          if (pat_ovf) begin
            res_status = rss_pkg::ST_OVERFLOW;
          end else if (pat_len == '0) begin
            res_status = rss_pkg::ST_FOUND;
          end else begin
            res_status = rss_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // Hold the item only while its result cannot enter the output register.
  assign s1_fire    = s1_valid_q && (!has_res || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_comb begin
    pat_cmd.clear   = s1_fire && (kind_q == rss_pkg::KIND_CLEAR);
    pat_cmd.append  = s1_fire && (kind_q == rss_pkg::KIND_APPEND);
    win_cmd.shift   = s1_fire && (kind_q == rss_pkg::KIND_TEXT);
    win_cmd.restart = s1_fire && (kind_q != rss_pkg::KIND_TEXT);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end

    done_d = done_q;
    if (win_cmd.restart) begin
      done_d = 1'b0;
    end else if (win_cmd.shift && has_res) begin
      done_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    status_d    = status_q;
    pos_d       = pos_q;
    if (s1_fire && has_res) begin
      out_valid_d = 1'b1;
      status_d    = res_status;
      pos_d       = res_pos;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= rss_pkg::kind_e'(kind_i);
      byte_q <= byte_value_i;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_position_o = pos_q;

  a_pos_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q != rss_pkg::ST_FOUND) |-> match_position_o == '0)
    else $error("nonzero position on a result other than found");

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i && has_res)
    else $error("input stalled without a blocked result");

  a_text_result_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && has_res && (kind_q == rss_pkg::KIND_TEXT) |=> done_q && out_valid_q)
    else $error("found result did not end the search");

  a_overflow_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_ovf |-> pat_len == LenW'(MAX_PATTERN))
    else $error("overflow flagged below pattern capacity");

  a_no_text_result_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && s1_fire && (kind_q == rss_pkg::KIND_TEXT) |=> $stable(out_valid_q) ||
    $fell(out_valid_q))
    else $error("second result after a reported match");

endmodule

>>> tb/tb_rolling_sum_substring_search.sv
// Self-checking testbench for the rolling-sum substring search block.
module tb_rolling_sum_substring_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAT_MAX     = 16;
  localparam int unsigned COUNT_LIMIT = 65535;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct {
    rss_pkg::kind_e kind;
    logic [7:0]     value;
  } beat_t;

  typedef struct {
    rss_pkg::status_e status;
    logic [15:0]      pos;
  } report_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready_o;
  rss_pkg::kind_e kind_drv = rss_pkg::KIND_CLEAR;
  logic [7:0]     byte_drv = 8'h00;
  logic           out_valid_o;
  logic           out_ready = 1'b0;
  logic [1:0]     status_o;
  logic [15:0]    match_position_o;

  rolling_sum_substring_search DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_drv),
    .byte_value_i     (byte_drv),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .match_position_o (match_position_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  beat_t   item_q[$];
  report_t search_reports_q[$];
  int      queued = 0;
  int      errors = 0;
  int      stall_cycles = 0;
  int      snd_idle_pct = 26;
  int      rcv_idle_pct = 85;

  // predictor state
  logic [7:0]  pat_mem [PAT_MAX];
  int unsigned pat_len = 0;
  logic [11:0] pat_sum = '0;
  bit          pat_ovf = 1'b0;
  logic [7:0]  win [PAT_MAX];
  logic [11:0] win_sum = '0;
  int unsigned txt_cnt = 0;
  bit          found = 1'b0;

  beat_t   next_beat;
  report_t exp_rpt;
  bit      has_rpt;

  function automatic void clear_window();
    for (int i = 0; i < PAT_MAX; i++) win[i] = 8'h00;
    win_sum = '0;
    txt_cnt = 0;
    found   = 1'b0;
  endfunction

  function automatic void search_step(input rss_pkg::kind_e k, input logic [7:0] b,
                                      output bit has, output report_t rpt);
    logic [7:0] leaving;
    bit         hit;
    has        = 1'b0;
    rpt.status = rss_pkg::ST_NOT_FOUND;
    rpt.pos    = '0;
    case (k)
      rss_pkg::KIND_CLEAR: begin
        pat_len = 0;
        pat_sum = '0;
        pat_ovf = 1'b0;
        clear_window();
      end
      rss_pkg::KIND_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_mem[pat_len] = b;
          pat_len++;
          pat_sum = pat_sum + b;
        end else begin
          pat_ovf = 1'b1;
        end
        clear_window();
      end
      rss_pkg::KIND_TEXT: begin
        if (pat_len > 0) begin
          leaving = win[pat_len-1];
          win_sum = win_sum + b - leaving;
        end
        for (int i = PAT_MAX - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (txt_cnt < COUNT_LIMIT) txt_cnt++;
        if (!found && !pat_ovf) begin
          if (pat_len == 0) begin
            found      = 1'b1;
            has        = 1'b1;
            rpt.status = rss_pkg::ST_FOUND;
          end else if (txt_cnt >= pat_len && win_sum == pat_sum) begin
            hit = 1'b1;
            // oldest window byte lines up with the first pattern byte
            for (int i = 0; i < pat_len; i++)
              if (win[pat_len-1-i] != pat_mem[i]) hit = 1'b0;
            if (hit) begin
              found      = 1'b1;
              has        = 1'b1;
              rpt.status = rss_pkg::ST_FOUND;
              rpt.pos    = (txt_cnt < COUNT_LIMIT) ? 16'(txt_cnt - pat_len) : 16'(COUNT_LIMIT);
            end
          end
        end
      end
      rss_pkg::KIND_END: begin
        if (!found) begin
          has = 1'b1;
          if (pat_ovf) rpt.status = rss_pkg::ST_OVERFLOW;
          else if (pat_len == 0) rpt.status = rss_pkg::ST_FOUND;
          else rpt.status = rss_pkg::ST_NOT_FOUND;
        end
        clear_window();
      end
      default: ;
    endcase
  endfunction

  // input driver: hold the beat until accepted, then maybe idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      kind_drv <= rss_pkg::KIND_CLEAR;
      byte_drv <= 8'h00;
    end else if (!in_valid || in_ready_o) begin
      if (item_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        next_beat = item_q.pop_front();
        in_valid <= 1'b1;
        kind_drv <= next_beat.kind;
        byte_drv <= next_beat.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // predict on input beats, check on output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        search_step(kind_drv, byte_drv, has_rpt, exp_rpt);
        if (has_rpt) search_reports_q.push_back(exp_rpt);
      end
      if (out_valid_o && out_ready) begin
        if (search_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status=%0d pos=%0d",
                   $time, status_o, match_position_o);
          errors++;
        end else begin
          exp_rpt = search_reports_q.pop_front();
          if (status_o !== exp_rpt.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_rpt.status, status_o);
            errors++;
          end
          if (match_position_o !== exp_rpt.pos) begin
            $display("%0t: match_position mismatch, expected %0d, actual %0d",
                     $time, exp_rpt.pos, match_position_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push(rss_pkg::kind_e k, logic [7:0] v);
    beat_t bt;
    bt.kind  = k;
    bt.value = v;
    item_q.push_back(bt);
    queued++;
  endtask

  function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] a, logic [7:0] b);
    if (narrow) return $urandom_range(1) ? a : b;
    return 8'($urandom_range(255));
  endfunction

  // clear, load a pattern, stream one or two texts with an optional planted copy
  task automatic search_case();
    int unsigned len;
    int unsigned tlen;
    int unsigned ofs;
    int unsigned sel;
    int unsigned passes;
    bit          narrow;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  pat [PAT_MAX];
    logic [7:0]  txt [32];
    sel = $urandom_range(99);
    if (sel < 5) len = 0;
    else if (sel < 80) len = $urandom_range(1, 4);
    else len = $urandom_range(5, PAT_MAX);
    narrow = $urandom_range(1);
    sa = 8'($urandom_range(255));
    sb = 8'($urandom_range(255));
    push(rss_pkg::KIND_CLEAR, 8'($urandom_range(255)));
    for (int i = 0; i < len; i++) begin
      pat[i] = pick_byte(narrow, sa, sb);
      push(rss_pkg::KIND_APPEND, pat[i]);
    end
    passes = $urandom_range(1, 2);
    for (int p = 0; p < passes; p++) begin
      if ($urandom_range(9) == 0 && len > 0) tlen = len - 1;
      else tlen = $urandom_range(0, 24);
      for (int i = 0; i < tlen; i++) txt[i] = pick_byte(narrow, sa, sb);
      if (tlen >= len && $urandom_range(99) < 60) begin
        ofs = $urandom_range(0, tlen - len);
        for (int j = 0; j < len; j++) txt[ofs+j] = pat[j];
      end
      for (int i = 0; i < tlen; i++) push(rss_pkg::KIND_TEXT, txt[i]);
      push(rss_pkg::KIND_END, 8'($urandom_range(255)));
    end
  endtask

  task automatic overflow_case();
    int unsigned extra;
    extra = $urandom_range(1, 3);
    push(rss_pkg::KIND_CLEAR, 8'($urandom_range(255)));
    for (int i = 0; i < PAT_MAX + extra; i++)
      push(rss_pkg::KIND_APPEND, 8'($urandom_range(255)));
    for (int i = 0; i < $urandom_range(0, 8); i++)
      push(rss_pkg::KIND_TEXT, 8'($urandom_range(255)));
    push(rss_pkg::KIND_END, 8'($urandom_range(255)));
    if ($urandom_range(1)) push(rss_pkg::KIND_END, 8'($urandom_range(255)));
  endtask

  // an append lands in the middle of the text and restarts the search
  task automatic broken_case();
    logic [7:0] sa;
    logic [7:0] sb;
    sa = 8'($urandom_range(255));
    sb = 8'($urandom_range(255));
    push(rss_pkg::KIND_CLEAR, 8'($urandom_range(255)));
    for (int i = 0; i < $urandom_range(1, 3); i++)
      push(rss_pkg::KIND_APPEND, pick_byte(1'b1, sa, sb));
    for (int i = 0; i < $urandom_range(0, 6); i++)
      push(rss_pkg::KIND_TEXT, pick_byte(1'b1, sa, sb));
    push(rss_pkg::KIND_APPEND, pick_byte(1'b1, sa, sb));
    for (int i = 0; i < $urandom_range(0, 8); i++)
      push(rss_pkg::KIND_TEXT, pick_byte(1'b1, sa, sb));
    if ($urandom_range(1)) push(rss_pkg::KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic random_items(int n);
    int start;
    int sel;
    start = queued;
    while (queued - start < n) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        search_case();
      end else if (sel < 73) begin
        overflow_case();
      end else if (sel < 88) begin
        for (int i = 0; i < $urandom_range(4, 16); i++)
          push(rss_pkg::kind_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        broken_case();
      end
    end
  endtask

  task automatic drain();
    while (item_q.size() != 0 || in_valid || search_reports_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < PAT_MAX; i++) win[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty pattern on empty text and on a first byte; byte ignored on end
    push(rss_pkg::KIND_END, 8'hFF);
    push(rss_pkg::KIND_TEXT, 8'hFF);
    push(rss_pkg::KIND_TEXT, 8'h00);
    push(rss_pkg::KIND_END, 8'h00);
    // zero byte in the pattern; text shorter than the pattern
    push(rss_pkg::KIND_APPEND, 8'h00);
    push(rss_pkg::KIND_APPEND, 8'hFF);
    push(rss_pkg::KIND_TEXT, 8'h00);
    push(rss_pkg::KIND_END, 8'hFF);
    // equal sums with the bytes swapped, then the real match at 1
    push(rss_pkg::KIND_TEXT, 8'hFF);
    push(rss_pkg::KIND_TEXT, 8'h00);
    push(rss_pkg::KIND_TEXT, 8'hFF);
    push(rss_pkg::KIND_END, 8'h00);
    push(rss_pkg::KIND_CLEAR, 8'hFF);
    push(rss_pkg::KIND_TEXT, 8'h55);
    push(rss_pkg::KIND_END, 8'hAA);
    random_items(170);
    drain();

    snd_idle_pct = 85;
    rcv_idle_pct = 26;
    random_items(170);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_items(170);
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rss_pkg.sv
sv/rss_pattern.sv
sv/rss_window.sv
sv/rolling_sum_substring_search.sv
tb/tb_rolling_sum_substring_search.sv
